FILE: src/mfm_pkg.sv
`default_nettype none

package mfm_pkg;

	localparam int TICK_WIDTH_DEF = 16;

	// fault flag bit positions
	localparam int FLAG_W  = 5;
	localparam int FLAG_OC = 0;
	localparam int FLAG_OV = 1;
	localparam int FLAG_UV = 2;
	localparam int FLAG_OL = 3;
	localparam int FLAG_HT = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		FUNC_COMMUTE = 2'd0,
		FUNC_FAST    = 2'd1,
		FUNC_SLOW    = 2'd2,
		FUNC_CLEAR   = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLANKING     = 3'd0,
		REG_OVER_VOLT    = 3'd1,
		REG_UNDER_VOLT   = 3'd2,
		REG_OVERLOAD     = 3'd3,
		REG_FILTER_SHIFT = 3'd4,
		REG_HALL_TIMEOUT = 3'd5
	} reg_idx_t;

	localparam logic [15:0] BLANKING_RST     = 16'd3;
	localparam logic [15:0] OVER_VOLT_RST    = 16'd32000;
	localparam logic [15:0] UNDER_VOLT_RST   = 16'd18000;
	localparam logic [15:0] OVERLOAD_RST     = 16'd1500;
	localparam logic [3:0]  FILTER_SHIFT_RST = 4'd7;
	localparam logic [15:0] HALL_TIMEOUT_RST = 16'd500;

	typedef struct packed {
		logic [15:0] blank_window;
		logic [15:0] over_voltage_mv;
		logic [15:0] under_voltage_mv;
		logic [15:0] overload_limit_ma;
		logic [3:0]  filter_shift;
		logic [15:0] hall_limit;
	} cfg_t;

	// input item without the tick, whose width follows the parameter
	typedef struct packed {
		func_t              func;
		logic               phase_over;
		logic               bus_over;
		logic [15:0]        vbus_mv;
		logic signed [15:0] ibus_ma;
		logic [15:0]        hall_age;
		logic               running;
		logic [FLAG_W-1:0]  clear_mask;
	} item_t;

	// first member is the MSB: fault_flags lands in the low bits
	typedef struct packed {
		logic [15:0]       filtered_current;
		logic              gate_off;
		logic              any_fault;
		logic [FLAG_W-1:0] fault_flags;
	} result_t;

	localparam int RES_W = $bits(result_t);
	localparam int OUT_W = ((RES_W + 7) / 8) * 8;

endpackage

`default_nettype wire

FILE: src/mfm_cfg_regs.sv
`default_nettype none

module mfm_cfg_regs
	import mfm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blank_window      <= BLANKING_RST;
			cfg_q.over_voltage_mv   <= OVER_VOLT_RST;
			cfg_q.under_voltage_mv  <= UNDER_VOLT_RST;
			cfg_q.overload_limit_ma <= OVERLOAD_RST;
			cfg_q.filter_shift      <= FILTER_SHIFT_RST;
			cfg_q.hall_limit        <= HALL_TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BLANKING:     cfg_q.blank_window      <= wr_data;
				REG_OVER_VOLT:    cfg_q.over_voltage_mv   <= wr_data;
				REG_UNDER_VOLT:   cfg_q.under_voltage_mv  <= wr_data;
				REG_OVERLOAD:     cfg_q.overload_limit_ma <= wr_data;
				REG_FILTER_SHIFT: cfg_q.filter_shift      <= wr_data[3:0];
				REG_HALL_TIMEOUT: cfg_q.hall_limit        <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: src/mfm_eval.sv
`default_nettype none

module mfm_eval
	import mfm_pkg::*;
#(
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire item_t                 item,
	input  wire logic [TICK_WIDTH-1:0] tick,
	input  wire cfg_t                  cfg,
	output result_t                    res
);

	localparam int CMP_W = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;

	logic [FLAG_W-1:0]     flags_q;
	logic [TICK_WIDTH-1:0] stamp_q;
	logic [15:0]           filt_q;

	logic [TICK_WIDTH-1:0] age;
	logic                  trip;
	logic signed [16:0]    ibus_ext;
	logic [16:0]           iabs;
	logic signed [17:0]    diff;
	logic signed [17:0]    step;
	logic signed [17:0]    filt_sum;
	logic [15:0]           filt_upd;
	logic [15:0]           filt_next;
	logic [FLAG_W-1:0]     flags_next;

	// wrapping age since the last commutation
	assign age  = tick - stamp_q;
	assign trip = (item.func == FUNC_FAST) &&
		(CMP_W'(age) >= CMP_W'(cfg.blank_window)) &&
		(item.phase_over || item.bus_over);

	// |ibus| fits 17 bits, -32768 maps to 32768
	assign ibus_ext = {item.ibus_ma[15], item.ibus_ma};
	assign iabs     = item.ibus_ma[15] ? 17'(-ibus_ext) : 17'(ibus_ext);
	assign diff     = $signed({1'b0, iabs}) - $signed({2'b00, filt_q});
	assign step     = diff >>> cfg.filter_shift;
	assign filt_sum = $signed({2'b00, filt_q}) + step;
	assign filt_upd = filt_sum[15:0];

	always_comb begin
		flags_next = flags_q;
		filt_next  = filt_q;
		case (item.func)
			FUNC_FAST: begin
				if (trip)
					flags_next[FLAG_OC] = 1'b1;
			end
			FUNC_SLOW: begin
				if (item.vbus_mv > cfg.over_voltage_mv)
					flags_next[FLAG_OV] = 1'b1;
				else if (item.vbus_mv < cfg.under_voltage_mv)
					flags_next[FLAG_UV] = 1'b1;
				filt_next = filt_upd;
				if (filt_upd > cfg.overload_limit_ma)
					flags_next[FLAG_OL] = 1'b1;
				if (item.running && item.hall_age > cfg.hall_limit)
					flags_next[FLAG_HT] = 1'b1;
			end
			FUNC_CLEAR: flags_next = flags_q & ~item.clear_mask;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			stamp_q <= '0;
			filt_q  <= '0;
		end else if (en) begin
			flags_q <= flags_next;
			filt_q  <= filt_next;
			if (item.func == FUNC_COMMUTE)
				stamp_q <= tick;
		end
	end

	assign res.fault_flags      = flags_next;
	assign res.any_fault        = |flags_next;
	assign res.gate_off         = trip;
	assign res.filtered_current = filt_next;

endmodule

`default_nettype wire

FILE: src/motor_fault_monitor.sv
// A request passes the input register and then the result register on its way to m_tdata.
// Throughput: one request per cycle while m_tready keeps up; the input register and the
// result register let a new request enter while a result waits for m_tready, if the input register is empty.
// The event logic and fault state update sit between those two registers.
// Reset (arst_n low): flags, timestamp and filter clear, registers take defaults.
`default_nettype none

module motor_fault_monitor
	import mfm_pkg::*;
#(
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// func, tick, phase_over, bus_over, vbus_mv, ibus_ma, hall_age,
	// running, clear_mask, zero pad
	input  wire logic [((TICK_WIDTH + 58 + 7) / 8) * 8 - 1:0] s_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// fault_flags, any_fault, gate_off, filtered_current, zero pad
	output logic [OUT_W-1:0]           m_tdata,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int OFF_TICK = 2;
	localparam int OFF_PO   = OFF_TICK + TICK_WIDTH;
	localparam int OFF_BO   = OFF_PO + 1;
	localparam int OFF_VBUS = OFF_BO + 1;
	localparam int OFF_IBUS = OFF_VBUS + 16;
	localparam int OFF_HALL = OFF_IBUS + 16;
	localparam int OFF_RUN  = OFF_HALL + 16;
	localparam int OFF_MASK = OFF_RUN + 1;

	cfg_t                  cfg;
	item_t                 item_in;
	item_t                 item_s1;
	logic [TICK_WIDTH-1:0] tick_s1;
	logic                  valid_s1;
	logic                  out_valid_q;
	result_t               res;
	result_t               res_q;
	logic                  out_free;
	logic                  adv;

	assign cfg_ready = 1'b1;

	mfm_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign item_in.func       = func_t'(s_tdata[1:0]);
	assign item_in.phase_over = s_tdata[OFF_PO];
	assign item_in.bus_over   = s_tdata[OFF_BO];
	assign item_in.vbus_mv    = s_tdata[OFF_VBUS +: 16];
	assign item_in.ibus_ma    = s_tdata[OFF_IBUS +: 16];
	assign item_in.hall_age   = s_tdata[OFF_HALL +: 16];
	assign item_in.running    = s_tdata[OFF_RUN];
	assign item_in.clear_mask = s_tdata[OFF_MASK +: FLAG_W];

	assign out_free = !out_valid_q || m_tready;
	assign adv      = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_in;
			tick_s1 <= s_tdata[OFF_TICK +: TICK_WIDTH];
		end
	end

	mfm_eval #(
		.TICK_WIDTH (TICK_WIDTH)
	) u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.tick   (tick_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(res_q);

	// a trip always leaves over-current latched
	a_gate_sets_oc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.gate_off |-> res_q.fault_flags[FLAG_OC])
		else $error("gate_off without over-current flag");

	a_any_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.any_fault == (res_q.fault_flags != '0)))
		else $error("any_fault disagrees with flags");

	a_filter_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.filtered_current <= 16'd32768))
		else $error("filter out of range");

	// a stalled stage-one request is held, not dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1)
		else $error("stage one request lost");

	a_gate_only_fast: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.gate_off |-> (item_s1.func == FUNC_FAST))
		else $error("gate_off on non fast check");

endmodule

`default_nettype wire

FILE: bench/motor_fault_monitor_tb.sv
`default_nettype none

module motor_fault_monitor_tb;
	import mfm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int S_W         = ((TICK_WIDTH_DEF + 58 + 7) / 8) * 8;
	localparam int SETTLE      = 4;
	localparam int LONG_HOLD   = 300;
	localparam int CYCLE_LIMIT = 500000;

	// tracks flags, timestamp and filter; queues the fault report each request produces
	class fault_flag_tracker;
		cfg_t              regs;
		logic [FLAG_W-1:0] flags;
		logic [15:0]       stamp;
		int                filt;
		result_t           fault_reports[$];
		int                errors;

		function new();
			regs.blank_window      = BLANKING_RST;
			regs.over_voltage_mv   = OVER_VOLT_RST;
			regs.under_voltage_mv  = UNDER_VOLT_RST;
			regs.overload_limit_ma = OVERLOAD_RST;
			regs.filter_shift      = FILTER_SHIFT_RST;
			regs.hall_limit        = HALL_TIMEOUT_RST;
			flags  = '0;
			stamp  = '0;
			filt   = 0;
			errors = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [15:0] val);
			case (idx)
				REG_BLANKING:     regs.blank_window      = val;
				REG_OVER_VOLT:    regs.over_voltage_mv   = val;
				REG_UNDER_VOLT:   regs.under_voltage_mv  = val;
				REG_OVERLOAD:     regs.overload_limit_ma = val;
				REG_FILTER_SHIFT: regs.filter_shift      = val[3:0];
				REG_HALL_TIMEOUT: regs.hall_limit        = val;
				default: ;
			endcase
		endfunction

		function void note_request(logic [S_W-1:0] d);
			func_t              f;
			logic [15:0]        tick, vbus, hall, age;
			logic signed [15:0] ibus;
			logic               po, bo, run, trip;
			logic [FLAG_W-1:0]  mask;
			int                 mag, diff;
			result_t            rep;
			f    = func_t'(d[1:0]);
			tick = d[17:2];
			po   = d[18];
			bo   = d[19];
			vbus = d[35:20];
			ibus = d[51:36];
			hall = d[67:52];
			run  = d[68];
			mask = d[73:69];
			trip = 1'b0;
			case (f)
				FUNC_COMMUTE: stamp = tick;
				FUNC_FAST: begin
					age = tick - stamp;
					if (age >= regs.blank_window && (po || bo)) begin
						flags[FLAG_OC] = 1'b1;
						trip = 1'b1;
					end
				end
				FUNC_SLOW: begin
					if (vbus > regs.over_voltage_mv)
						flags[FLAG_OV] = 1'b1;
					else if (vbus < regs.under_voltage_mv)
						flags[FLAG_UV] = 1'b1;
					mag  = (ibus < 0) ? -int'(ibus) : int'(ibus);
					diff = mag - filt;
					// int is signed, so this floors toward minus infinity
					filt = filt + (diff >>> regs.filter_shift);
					if (filt > int'(regs.overload_limit_ma))
						flags[FLAG_OL] = 1'b1;
					if (run && hall > regs.hall_limit)
						flags[FLAG_HT] = 1'b1;
				end
				default: flags = flags & ~mask;
			endcase
			rep.fault_flags      = flags;
			rep.any_fault        = (flags != '0);
			rep.gate_off         = trip;
			rep.filtered_current = 16'(filt);
			fault_reports.push_back(rep);
		endfunction

		function void check_result(logic [OUT_W-1:0] d);
			result_t got, want;
			got = result_t'(d[RES_W-1:0]);
			if (fault_reports.size() == 0) begin
				$error("unexpected result %0h with no request outstanding", d);
				errors++;
				return;
			end
			want = fault_reports.pop_front();
			if (got.fault_flags !== want.fault_flags) begin
				$error("fault_flags: expected %0h, actual %0h", want.fault_flags, got.fault_flags);
				errors++;
			end
			if (got.any_fault !== want.any_fault) begin
				$error("any_fault: expected %0b, actual %0b", want.any_fault, got.any_fault);
				errors++;
			end
			if (got.gate_off !== want.gate_off) begin
				$error("gate_off: expected %0b, actual %0b", want.gate_off, got.gate_off);
				errors++;
			end
			if (got.filtered_current !== want.filtered_current) begin
				$error("filtered_current: expected %0d, actual %0d",
					want.filtered_current, got.filtered_current);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// func, tick, phase_over, bus_over, vbus_mv, ibus_ma, hall_age,
	// running, clear_mask, zero pad
	logic [S_W-1:0]        s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	// fault_flags, any_fault, gate_off, filtered_current, zero pad
	logic [OUT_W-1:0]      m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  hold_req;
	logic                  hold_done;
	int unsigned           cycle_count = 0;

	fault_flag_tracker sb = new();

	motor_fault_monitor i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// results first, so a stray result cannot consume a request noted this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (s_tvalid && s_tready)
				sb.note_request(s_tdata);
		end
	end

	// result side: stall pattern redrawn every segment, plus one long hold-off
	initial begin
		int seg_left, mode, hold_left;
		m_tready  = 1'b0;
		hold_done = 1'b0;
		seg_left  = 0;
		mode      = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready = 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode     = $urandom_range(0, 3);
					seg_left = $urandom_range(20, 150);
				end
				seg_left--;
				case (mode)
					0: m_tready = 1'b1;
					1: m_tready = 1'($urandom_range(0, 1));
					2: m_tready = ($urandom_range(0, 3) != 0);
					default: m_tready = ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	function automatic logic [S_W-1:0] make_request(func_t f, logic [15:0] tick, logic po,
		logic bo, logic [15:0] vbus, logic signed [15:0] ibus, logic [15:0] hall,
		logic run, logic [FLAG_W-1:0] mask);
		return {6'b0, mask, run, hall, ibus, vbus, bo, po, tick, f};
	endfunction

	function automatic logic [S_W-1:0] rand_request();
		func_t              f;
		logic [15:0]        tick, vbus, hall;
		logic signed [15:0] ibus;
		f = func_t'($urandom_range(0, 3));
		// mostly land near the end of the blanking window
		if ($urandom_range(0, 3) == 0)
			tick = 16'($urandom);
		else
			tick = 16'(sb.stamp + sb.regs.blank_window + $urandom_range(0, 4) - 2);
		case ($urandom_range(0, 4))
			0: vbus = 16'(sb.regs.over_voltage_mv + $urandom_range(0, 2) - 1);
			1: vbus = 16'(sb.regs.under_voltage_mv + $urandom_range(0, 2) - 1);
			2: vbus = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: vbus = 16'($urandom);
		endcase
		case ($urandom_range(0, 4))
			0: ibus = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
			1: begin
				ibus = 16'(sb.regs.overload_limit_ma + $urandom_range(0, 2) - 1);
				if ($urandom_range(0, 1))
					ibus = -ibus;
			end
			default: ibus = 16'($urandom);
		endcase
		if ($urandom_range(0, 2) == 0)
			hall = 16'(sb.regs.hall_limit + $urandom_range(0, 2) - 1);
		else
			hall = 16'($urandom);
		return make_request(f, tick, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			vbus, ibus, hall, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(logic [S_W-1:0] d);
		s_tvalid = 1'b1;
		s_tdata  = d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		s_tvalid = 1'b0;
		while (sb.fault_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic program_phase(int kind);
		cfg_t c;
		case (kind)
			0: c = '{default: '0};
			1: begin
				c.blank_window      = 16'hFFFF;
				c.over_voltage_mv   = 16'hFFFF;
				c.under_voltage_mv  = 16'hFFFF;
				c.overload_limit_ma = 16'd32768;
				c.filter_shift      = 4'd15;
				c.hall_limit        = 16'hFFFF;
			end
			2: begin
				c.blank_window      = 16'($urandom_range(1, 200));
				c.over_voltage_mv   = 16'd32000;
				c.under_voltage_mv  = 16'd18000;
				c.overload_limit_ma = 16'd1500;
				c.filter_shift      = 4'd2;
				c.hall_limit        = 16'd500;
			end
			default: begin
				if ($urandom_range(0, 3) == 0)
					c.blank_window = 16'($urandom);
				else
					c.blank_window = 16'($urandom_range(0, 64));
				c.over_voltage_mv   = 16'($urandom);
				c.under_voltage_mv  = 16'($urandom);
				c.overload_limit_ma = 16'($urandom_range(0, 32768));
				c.filter_shift      = 4'($urandom_range(0, 15));
				c.hall_limit        = 16'($urandom);
			end
		endcase
		write_reg(REG_BLANKING, c.blank_window);
		write_reg(REG_OVER_VOLT, c.over_voltage_mv);
		write_reg(REG_UNDER_VOLT, c.under_voltage_mv);
		write_reg(REG_OVERLOAD, c.overload_limit_ma);
		write_reg(REG_FILTER_SHIFT, {12'b0, c.filter_shift});
		write_reg(REG_HALL_TIMEOUT, c.hall_limit);
		cfg_valid = 1'b0;
	endtask

	// bursts of random length, random gaps, now and then a long unbroken run
	task automatic random_traffic(int count);
		int sent, burst;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) == 0)
				burst = $urandom_range(40, 80);
			else
				burst = $urandom_range(1, 30);
			for (int k = 0; k < burst && sent < count; k++) begin
				send_request(rand_request());
				sent++;
			end
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid = 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_BLANKING;
		cfg_data  = '0;
		hold_req  = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// commutation with every unused input high, but ibus at its most negative value
		send_request(make_request(FUNC_COMMUTE, 16'hFFFE, 1'b1, 1'b1, 16'hFFFF, 16'sh8000,
			16'hFFFF, 1'b1, 5'h1F));
		// tick wraps: age 2 is still blanked, age 3 trips
		send_request(make_request(FUNC_FAST, 16'h0000, 1'b1, 1'b0, '0, '0, '0, 1'b0, '0));
		send_request(make_request(FUNC_FAST, 16'h0001, 1'b1, 1'b0, '0, '0, '0, 1'b0, '0));
		// trips again while already latched
		send_request(make_request(FUNC_FAST, 16'h0001, 1'b0, 1'b1, '0, '0, '0, 1'b0, '0));
		send_request(make_request(FUNC_FAST, 16'h0002, 1'b0, 1'b0, 16'hFFFF, 16'sh7FFF,
			16'hFFFF, 1'b1, 5'h1F));
		send_request(make_request(FUNC_SLOW, '0, 1'b0, 1'b0, 16'hFFFF, 16'sh8000, 16'hFFFF,
			1'b1, '0));
		send_request(make_request(FUNC_SLOW, 16'hFFFF, 1'b1, 1'b1, 16'h0000, 16'sh7FFF,
			16'hFFFF, 1'b0, 5'h1F));
		// thresholds exactly: nothing flagged
		send_request(make_request(FUNC_SLOW, '0, 1'b0, 1'b0, 16'd32000, 16'sh0000, 16'd500,
			1'b1, '0));
		send_request(make_request(FUNC_SLOW, '0, 1'b0, 1'b0, 16'd18000, -16'sd1, 16'd501,
			1'b0, '0));
		send_request(make_request(FUNC_CLEAR, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 16'sh8000,
			16'hFFFF, 1'b1, 5'h1F));
		send_request(make_request(FUNC_COMMUTE, 16'h0000, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0));
		send_request(make_request(FUNC_FAST, 16'hFFFF, 1'b1, 1'b1, '0, '0, '0, 1'b0, '0));
		send_request(make_request(FUNC_CLEAR, '0, 1'b0, 1'b0, '0, '0, '0, 1'b0, 5'h01));
		// pump the filter past the overload limit
		for (int k = 0; k < 8; k++)
			send_request(make_request(FUNC_SLOW, '0, 1'b0, 1'b0, 16'd25000, 16'sh8000, '0,
				1'b0, '0));
		send_request(make_request(FUNC_CLEAR, '0, 1'b0, 1'b0, '0, '0, '0, 1'b0, 5'h08));
		send_request(make_request(FUNC_SLOW, '0, 1'b0, 1'b0, 16'd25000, 16'sh0000, '0,
			1'b0, '0));
		send_request(make_request(FUNC_CLEAR, '0, 1'b0, 1'b0, '0, '0, '0, 1'b0, 5'h00));

		for (int p = 0; p < 8; p++) begin
			hold_until_drained();
			program_phase(p);
			random_traffic(50);
			if (p == 3) begin
				// keep offering while the result side holds off
				hold_req = 1'b1;
				for (int k = 0; k < 40; k++)
					send_request(rand_request());
			end
			if (p == 5)
				hold_until_drained();
			random_traffic(50);
		end

		hold_until_drained();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.fault_reports.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

FILE: motor_fault_monitor.f
src/mfm_pkg.sv
src/mfm_cfg_regs.sv
src/mfm_eval.sv
src/motor_fault_monitor.sv
bench/motor_fault_monitor_tb.sv
